### hdl/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/orol_pkg.sv
// Types and constants shared by the ring offset lookup files.
package orol_pkg;

  // Field widths of the request and response transactions.
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned BYTE_W   = 16;

  // Request kinds.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot_index;
    logic [HANDLE_W-1:0] found_handle;
    logic [BYTE_W-1:0]   byte_within_entry;
    logic                replaced_valid;
    logic [HANDLE_W-1:0] replaced_handle;
  } rsp_t;

  // Status flags of the sequencer.
  typedef struct packed {
    logic full;
    logic ptr_eq;
    logic idle;
    logic pend;
  } status_t;

endpackage

### hdl/orol_req_if.sv
// Request channel interface: valid, ready and the request payload.
interface orol_req_if;
  logic          valid;
  logic          ready;
  orol_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/orol_rsp_if.sv
// Response channel interface: valid, ready and the response payload.
interface orol_rsp_if;
  logic          valid;
  logic          ready;
  orol_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/orol_ring_mem.sv
// Ring entry memory: one write port and one registered read port.
module orol_ring_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write first in program order; a read of the same entry in the same cycle sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata <= mem_q[raddr];
  end

endmodule

### hdl/orol_seq.sv
// Sequencer: ring pointers, add and find walks over the entry memory, result holding.
module orol_seq #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  orol_pkg::req_t                      req_data,
  output logic                                req_ready,
  input  logic                                res_take,
  output logic                                res_pend,
  output orol_pkg::rsp_t                      res_data,
  output orol_pkg::status_t                   status,
  output logic                                mem_we,
  output logic [$clog2(DEPTH)-1:0]            mem_waddr,
  output logic [HANDLE_BITS+LENGTH_BITS-1:0]  mem_wdata,
  output logic [$clog2(DEPTH)-1:0]            mem_raddr,
  input  logic [HANDLE_BITS+LENGTH_BITS-1:0]  mem_rdata
);

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SPAN_W  = PTR_W + 1;
  localparam int unsigned SUM_W   = LENGTH_BITS + CNT_W;
  localparam int unsigned ACC_W   = (SUM_W > orol_pkg::OFFSET_W) ? SUM_W : orol_pkg::OFFSET_W;
  localparam int unsigned ENTRY_W = HANDLE_BITS + LENGTH_BITS;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPL,
    S_WALK
  } state_t;

  state_t             state;
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   rp;
  logic               full;
  logic               pend;
  orol_pkg::rsp_t     res;
  logic [PTR_W-1:0]   cur;
  logic [CNT_W-1:0]   remain;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   target;
  logic [ENTRY_W-1:0] new_entry;

  logic                   accept;
  logic [ENTRY_W-1:0]     req_entry;
  logic [SPAN_W-1:0]      span;
  logic [CNT_W-1:0]       count;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [LENGTH_BITS-1:0] rd_len;
  logic [ACC_W-1:0]       sum;
  logic                   hit;
  logic [PTR_W-1:0]       wp_inc;
  logic [PTR_W-1:0]       rp_inc;
  logic [PTR_W-1:0]       cur_inc;
  orol_pkg::rsp_t         repl_res;
  orol_pkg::rsp_t         hit_res;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // Handshake and incoming entry.
  assign req_ready = (state == S_IDLE) && !pend;
  assign accept    = req_valid && req_ready;
  assign req_entry = {HANDLE_BITS'(req_data.entry_handle), LENGTH_BITS'(req_data.entry_size)};

  assign wp_inc  = next_ptr(wp);
  assign rp_inc  = next_ptr(rp);
  assign cur_inc = next_ptr(cur);

  // Number of stored entries.
  assign span  = (wp >= rp) ? SPAN_W'(wp) - SPAN_W'(rp)
                            : SPAN_W'(wp) + SPAN_W'(DEPTH) - SPAN_W'(rp);
  assign count = full ? CNT_W'(DEPTH) : CNT_W'(span);

  // Memory access: the idle cycle reads the oldest entry, the walk reads one slot ahead.
  assign mem_raddr = (state == S_WALK) ? cur_inc : rp;
  assign mem_waddr = wp;
  assign mem_we    = (accept && (req_data.kind == orol_pkg::KIND_ADD) && !full)
                   || (state == S_REPL);
  assign mem_wdata = (state == S_REPL) ? new_entry : req_entry;

  // Entry read back and the running length sum.
  assign rd_handle = mem_rdata[ENTRY_W-1:LENGTH_BITS];
  assign rd_len    = mem_rdata[LENGTH_BITS-1:0];
  assign sum       = acc + ACC_W'(rd_len);
  assign hit       = target < sum;

  // Result words for the overwrite and the found cases.
  always_comb begin
    repl_res                 = '0;
    repl_res.replaced_valid  = 1'b1;
    repl_res.replaced_handle = orol_pkg::HANDLE_W'(rd_handle);
    hit_res                   = '0;
    hit_res.found             = 1'b1;
    hit_res.slot_index        = orol_pkg::SLOT_W'(cur);
    hit_res.found_handle      = orol_pkg::HANDLE_W'(rd_handle);
    hit_res.byte_within_entry = orol_pkg::BYTE_W'(target - acc);
  end

  // State, pointers and the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      rp    <= '0;
      full  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      if (res_take) begin
        pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_data.kind == orol_pkg::KIND_ADD) begin
              if (full) begin
                new_entry <= req_entry;
                state     <= S_REPL;
              end else begin
                wp   <= wp_inc;
                full <= (wp_inc == rp);
                res  <= '0;
                pend <= 1'b1;
              end
            end else begin
              target <= ACC_W'(req_data.byte_offset);
              acc    <= '0;
              cur    <= rp;
              remain <= count;
              if (count == '0) begin
                res  <= '0;
                pend <= 1'b1;
              end else begin
                state <= S_WALK;
              end
            end
          end
        end
        S_REPL: begin
          res   <= repl_res;
          pend  <= 1'b1;
          rp    <= rp_inc;
          wp    <= wp_inc;
          state <= S_IDLE;
        end
        S_WALK: begin
          if (hit) begin
            res   <= hit_res;
            pend  <= 1'b1;
            state <= S_IDLE;
          end else if (remain == CNT_W'(1)) begin
            res   <= '0;
            pend  <= 1'b1;
            state <= S_IDLE;
          end else begin
            acc    <= sum;
            cur    <= cur_inc;
            remain <= remain - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_pend = pend;
  assign res_data = res;

  assign status.full   = full;
  assign status.ptr_eq = (wp == rp);
  assign status.idle   = (state == S_IDLE);
  assign status.pend   = pend;

endmodule

### hdl/overwriting_ring_offset_lookup.sv
// Top level of the overwriting ring with byte-offset lookup.
// Each request transaction gives exactly one response transaction. An add holds its result
// in the sequencer at the edge that accepts it, or after a pass through the replace state
// when the ring is full, because the oldest entry must first be read from the entry memory
// before it is overwritten. A find checks one stored entry per cycle, oldest first, because
// the walk reads one length a cycle through the single read port of the entry memory; its
// result is held once the matching entry or the last stored entry has been checked, or at
// once when the ring is empty. The result then passes through the output register before
// the response is valid, and the next request is taken the cycle after the result has moved
// there, even while the response waits. The entry memory needs no clearing after reset:
// only entries between the read and write pointers are ever used.
`include "assert_macros.svh"

module overwriting_ring_offset_lookup #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  orol_req_if.sink   req,
  orol_rsp_if.source rsp
);

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned ENTRY_W = HANDLE_BITS + LENGTH_BITS;

  logic               res_pend;
  logic               res_take;
  orol_pkg::rsp_t     res_data;
  orol_pkg::status_t  status;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [PTR_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  orol_ring_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  orol_seq #(
    .DEPTH       (DEPTH),
    .LENGTH_BITS (LENGTH_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_data  (req.data),
    .req_ready (req.ready),
    .res_take  (res_take),
    .res_pend  (res_pend),
    .res_data  (res_data),
    .status    (status),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: loads a held result whenever it is empty or being emptied.
  assign res_take = res_pend && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
      rsp.data  <= res_data;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // A full ring always has its pointers together.
  `ASSERT_IMP(a_full_ptr_eq, clk, rst, status.full, status.ptr_eq)
  // A held result is never dropped before the output register takes it.
  `ASSERT_NEXT(a_pend_held, clk, rst, status.pend && !res_take, status.pend)
  // A result taken from the sequencer shows up as a response transaction.
  `ASSERT_NEXT(a_take_shows, clk, rst, res_take, rsp.valid)
  // A response reports either a find hit or an overwrite, never both.
  `ASSERT_IMP(a_kind_excl, clk, rst, rsp.valid,
              !(rsp.data.found && rsp.data.replaced_valid))
  // A request is only accepted by an idle sequencer with no result held.
  `ASSERT_IMP(a_accept_idle, clk, rst, req.valid && req.ready, status.idle && !status.pend)

endmodule

### tb/tb.sv
// Self-checking testbench for the overwriting ring with byte-offset lookup.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RING_DEPTH  = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 24;

  // Tracks the ring contents and holds the responses still owed by the block.
  class ring_lookup_scoreboard;
    logic [orol_pkg::HANDLE_W-1:0] handles [RING_DEPTH];
    logic [orol_pkg::SIZE_W-1:0]   lengths [RING_DEPTH];
    int unsigned                   wr_slot;
    int unsigned                   rd_slot;
    bit                            full;
    orol_pkg::rsp_t                owed_responses [$];
    int unsigned                   failures;

    function new();
      wr_slot  = 0;
      rd_slot  = 0;
      full     = 1'b0;
      failures = 0;
    endfunction

    function int unsigned held_entries();
      return full ? RING_DEPTH : (wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH;
    endfunction

    // Total bytes of all held entries, oldest to newest.
    function longint unsigned held_bytes();
      longint unsigned total;
      int unsigned     k;
      total = 0;
      for (k = 0; k < held_entries(); k++) begin
        total += 64'(lengths[(rd_slot + k) % RING_DEPTH]);
      end
      return total;
    endfunction

    function int unsigned pending();
      return owed_responses.size();
    endfunction

    // Applies an accepted request to the ring and queues the response it owes.
    function void note_request(orol_pkg::req_t r);
      orol_pkg::rsp_t  e;
      longint unsigned acc;
      int unsigned     slot;
      int unsigned     count;
      int unsigned     k;
      e = '0;
      if (r.kind == orol_pkg::KIND_ADD) begin
        if (full) begin
          e.replaced_valid  = 1'b1;
          e.replaced_handle = handles[rd_slot];
          rd_slot = (rd_slot + 1) % RING_DEPTH;
        end
        handles[wr_slot] = r.entry_handle;
        lengths[wr_slot] = r.entry_size;
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        full = (wr_slot == rd_slot);
      end else begin
        // Walk the held entries oldest first; zero-length entries hold no byte.
        acc   = 0;
        slot  = rd_slot;
        count = held_entries();
        for (k = 0; k < count; k++) begin
          if (64'(r.byte_offset) < acc + 64'(lengths[slot])) begin
            e.found             = 1'b1;
            e.slot_index        = orol_pkg::SLOT_W'(slot);
            e.found_handle      = handles[slot];
            e.byte_within_entry = orol_pkg::BYTE_W'(64'(r.byte_offset) - acc);
            break;
          end
          acc += 64'(lengths[slot]);
          slot = (slot + 1) % RING_DEPTH;
        end
      end
      owed_responses.push_back(e);
    endfunction

    function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      end
    endfunction

    // Compares an accepted response with the oldest owed one.
    function void check_response(orol_pkg::rsp_t got);
      orol_pkg::rsp_t e;
      if (owed_responses.size() == 0) begin
        failures++;
        $display("%0t: response with none owed, expected nothing, actual %h", $time, got);
        return;
      end
      e = owed_responses.pop_front();
      compare_field("found", 64'(e.found), 64'(got.found));
      compare_field("slot_index", 64'(e.slot_index), 64'(got.slot_index));
      compare_field("found_handle", 64'(e.found_handle), 64'(got.found_handle));
      compare_field("byte_within_entry", 64'(e.byte_within_entry),
                    64'(got.byte_within_entry));
      compare_field("replaced_valid", 64'(e.replaced_valid), 64'(got.replaced_valid));
      compare_field("replaced_handle", 64'(e.replaced_handle), 64'(got.replaced_handle));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  orol_req_if req_ch ();
  orol_rsp_if rsp_ch ();

  overwriting_ring_offset_lookup dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ring_lookup_scoreboard sb = new();

  int unsigned burst_left = 1;
  int unsigned ready_step = 0;
  logic [7:0]  ready_pattern = 8'hFF;
  int unsigned stall_cycles = 0;

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Response side: ready steps through an 8-bit pattern, redrawn at random as all ones or with bit 0 set.
  always @(posedge clk) begin
    ready_step <= ready_step + 1;
    if (ready_step % 40 == 0) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
    end
    rsp_ch.ready <= ready_pattern[ready_step % 8];
  end

  // Record every accepted transaction on both channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic orol_pkg::req_t make_add(logic [orol_pkg::HANDLE_W-1:0] handle,
                                              logic [orol_pkg::SIZE_W-1:0] size);
    orol_pkg::req_t r;
    r.kind         = orol_pkg::KIND_ADD;
    r.entry_handle = handle;
    r.entry_size   = size;
    r.byte_offset  = orol_pkg::OFFSET_W'($urandom());
    return r;
  endfunction

  function automatic orol_pkg::req_t make_find(logic [orol_pkg::OFFSET_W-1:0] offset);
    orol_pkg::req_t r;
    r.kind         = orol_pkg::KIND_FIND;
    r.entry_handle = $urandom();
    r.entry_size   = orol_pkg::SIZE_W'($urandom());
    r.byte_offset  = offset;
    return r;
  endfunction

  // Mostly short entries so that finds land inside the data; a few long ones.
  function automatic orol_pkg::req_t random_add();
    logic [orol_pkg::SIZE_W-1:0] size;
    case ($urandom_range(0, 19))
      0:       size = orol_pkg::SIZE_W'($urandom());
      1, 2:    size = orol_pkg::SIZE_W'($urandom_range(0, 4095));
      3:       size = '0;
      default: size = orol_pkg::SIZE_W'($urandom_range(0, 64));
    endcase
    return make_add($urandom(), size);
  endfunction

  // Offsets inside the held data, around its end, or anywhere.
  function automatic orol_pkg::req_t random_find(longint unsigned held);
    longint unsigned offset;
    case ($urandom_range(0, 9))
      6, 7:    offset = (held == 0) ? $urandom_range(0, 1) : held - 1 + $urandom_range(0, 2);
      8, 9:    offset = $urandom();
      default: offset = (held == 0) ? $urandom_range(0, 15) : $urandom_range(0, held - 1);
    endcase
    return make_find(orol_pkg::OFFSET_W'(offset));
  endfunction

  // Sends one request transaction; bursts of random length with random gaps between.
  task automatic issue(input orol_pkg::req_t r);
    int unsigned gap;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int unsigned k;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring, zero-length and maximal entries, boundaries, then wrap.
    issue(make_find('0));
    issue(make_add('0, '0));
    issue(make_add('1, '1));
    issue(make_add(32'h1234_5678, 16'd1));
    issue(make_find('0));
    issue(make_find(20'h0FFFE));
    issue(make_find(20'h0FFFF));
    issue(make_find(20'h10000));
    issue(make_find('1));
    for (k = 3; k < RING_DEPTH + 2; k++) begin
      issue(make_add(~k, (k == RING_DEPTH) ? '1 : orol_pkg::SIZE_W'(k * 1000)));
    end
    issue(make_find('0));
    issue(make_find(20'hF0000));

    // Random mix of adds and finds.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 4) < 3) issue(random_add());
      else issue(random_find(sb.held_bytes()));
    end
    req_ch.valid <= 1'b0;

    // One more edge so that the last accepted request has been noted.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/orol_pkg.sv
hdl/orol_req_if.sv
hdl/orol_rsp_if.sv
hdl/orol_ring_mem.sv
hdl/orol_seq.sv
hdl/overwriting_ring_offset_lookup.sv
tb/tb.sv
